// ----- rtl/core/bbd_pkg.sv -----
// bbd_pkg: shared types and constants of the bilinear bayer demosaic
// holds field widths, register indexes, colour codes and the filter lookup
// no dependencies

package bbd_pkg;

   // fixed field widths of the two channels and of the register port
   localparam int unsigned SAMPLE_W  = 16;
   localparam int unsigned COORD_W   = 12;
   localparam int unsigned DIM_W     = 13;
   localparam int unsigned PATTERN_W = 2;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned CSR_ADDR_W = 4;

   // register reset values
   localparam logic [DIM_W-1:0]     WIDTH_RESET   = 13'd640;
   localparam logic [DIM_W-1:0]     HEIGHT_RESET  = 13'd480;
   localparam logic [PATTERN_W-1:0] PATTERN_RESET = 2'd0;

   // register indexes (byte address / 4)
   typedef enum logic [1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1,
      CSR_CFA_PATTERN  = 2'd2,
      CSR_UNUSED       = 2'd3
   } csr_index_type;

   // filter tile codes
   typedef enum logic [PATTERN_W-1:0] {
      CFA_BGGR = 2'd0,
      CFA_GBRG = 2'd1,
      CFA_GRBG = 2'd2,
      CFA_RGGB = 2'd3
   } cfa_type;

   // colour of one filter site
   typedef enum logic [1:0] {
      COLOUR_RED   = 2'd0,
      COLOUR_GREEN = 2'd1,
      COLOUR_BLUE  = 2'd2
   } colour_type;

   // one result transaction
   typedef struct packed {
      logic [SAMPLE_W-1:0] red;
      logic [SAMPLE_W-1:0] green;
      logic [SAMPLE_W-1:0] blue;
      logic [COORD_W-1:0]  out_col;
      logic [COORD_W-1:0]  out_row;
      logic                frame_end;
   } rsp_item_type;

   // colour at a site, from the tile and the row and column parity
   function automatic colour_type site_colour(input cfa_type pattern,
                                              input logic row_odd,
                                              input logic col_odd);
      colour_type result;
      result = COLOUR_GREEN;
      case (pattern)
         CFA_BGGR: begin
            if (!row_odd && !col_odd) result = COLOUR_BLUE;
            else if (row_odd && col_odd) result = COLOUR_RED;
         end
         CFA_GBRG: begin
            if (!row_odd && col_odd) result = COLOUR_BLUE;
            else if (row_odd && !col_odd) result = COLOUR_RED;
         end
         CFA_GRBG: begin
            if (!row_odd && col_odd) result = COLOUR_RED;
            else if (row_odd && !col_odd) result = COLOUR_BLUE;
         end
         CFA_RGGB: begin
            if (!row_odd && !col_odd) result = COLOUR_RED;
            else if (row_odd && col_odd) result = COLOUR_BLUE;
         end
         default: result = COLOUR_GREEN;
      endcase
      return result;
   endfunction

endpackage

// ----- rtl/core/bbd_if.sv -----
// bbd_req_if, bbd_rsp_if: valid/ready channels of the demosaic
// raw sample channel and rgb result channel
// depends on bbd_pkg

interface bbd_req_if;
   logic                          valid;
   logic                          ready;
   logic [bbd_pkg::SAMPLE_W-1:0]  raw_pixel;
   logic                          frame_start;

   modport source (output valid, output raw_pixel, output frame_start, input ready);
   modport sink   (input valid, input raw_pixel, input frame_start, output ready);
endinterface

interface bbd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bbd_pkg::SAMPLE_W-1:0]  red;
   logic [bbd_pkg::SAMPLE_W-1:0]  green;
   logic [bbd_pkg::SAMPLE_W-1:0]  blue;
   logic [bbd_pkg::COORD_W-1:0]   out_col;
   logic [bbd_pkg::COORD_W-1:0]   out_row;
   logic                          frame_end;

   modport source (output valid, output red, output green, output blue,
                   output out_col, output out_row, output frame_end, input ready);
   modport sink   (input valid, input red, input green, input blue,
                   input out_col, input out_row, input frame_end, output ready);
endinterface

// ----- rtl/core/bbd_interp.sv -----
// bbd_interp: bilinear colour reconstruction of one 3x3 window centre
// rounded two- and four-sample means, selected by the site colour
// depends on bbd_pkg

module bbd_interp #(
   parameter int unsigned PW = 16
) (
   input  logic [PW-1:0]         win [9],
   input  bbd_pkg::cfa_type      pattern,
   input  logic                  row_odd,
   input  logic                  col_odd,
   output logic [PW-1:0]         red,
   output logic [PW-1:0]         green,
   output logic [PW-1:0]         blue
);

   logic [PW:0]         horiz_sum;
   logic [PW:0]         vert_sum;
   logic [PW+1:0]       cross_sum;
   logic [PW+1:0]       diag_sum;
   logic [PW-1:0]       horiz_avg;
   logic [PW-1:0]       vert_avg;
   logic [PW-1:0]       cross_avg;
   logic [PW-1:0]       diag_avg;
   bbd_pkg::colour_type centre_colour;
   bbd_pkg::colour_type horiz_colour;

   // rounded means; window is a b c / d e f / g h i in raster order
   assign horiz_sum = (PW+1)'(win[3]) + (PW+1)'(win[5]) + (PW+1)'(1);
   assign vert_sum  = (PW+1)'(win[1]) + (PW+1)'(win[7]) + (PW+1)'(1);
   assign cross_sum = (PW+2)'(win[1]) + (PW+2)'(win[3]) + (PW+2)'(win[5])
                    + (PW+2)'(win[7]) + (PW+2)'(2);
   assign diag_sum  = (PW+2)'(win[0]) + (PW+2)'(win[2]) + (PW+2)'(win[6])
                    + (PW+2)'(win[8]) + (PW+2)'(2);
   assign horiz_avg = horiz_sum[PW:1];
   assign vert_avg  = vert_sum[PW:1];
   assign cross_avg = cross_sum[PW+1:2];
   assign diag_avg  = diag_sum[PW+1:2];

   // colour of the centre and of its horizontal neighbours
   assign centre_colour = bbd_pkg::site_colour(pattern, row_odd, col_odd);
   assign horiz_colour  = bbd_pkg::site_colour(pattern, row_odd, !col_odd);

   // place the centre sample and the means by site colour
   always_comb begin
      red   = win[4];
      green = win[4];
      blue  = win[4];
      case (centre_colour)
         bbd_pkg::COLOUR_RED: begin
            green = cross_avg;
            blue  = diag_avg;
         end
         bbd_pkg::COLOUR_BLUE: begin
            green = cross_avg;
            red   = diag_avg;
         end
         bbd_pkg::COLOUR_GREEN: begin
            if (horiz_colour == bbd_pkg::COLOUR_RED) begin
               red  = horiz_avg;
               blue = vert_avg;
            end else begin
               red  = vert_avg;
               blue = horiz_avg;
            end
         end
         default: begin
            red   = win[4];
            green = win[4];
            blue  = win[4];
         end
      endcase
   end

endmodule

// ----- rtl/core/bayer_bilinear_demosaic_top.sv -----
// Bilinear bayer demosaic. Raw samples come in raster order, one per clock while ready
// is high, and each accepted sample at column >= 2 of row >= 2 yields one rgb pixel for
// the window centre one row up and one column left; the one-pixel border is not
// produced. A sample is read out of the line memory on acceptance, and the window,
// interpolation and memory write-back happen in the following cycle. Throughput is set
// by the single read and single write port of the line memory, one of each per clock;
// a three-entry result queue keeps the input open while the output is briefly stalled.
// The two line stores share one memory of MAX_WIDTH entries; it is not cleared after
// reset and needs no clearing pass. The user must write width, height and filter tile
// over the register port only between frames; the block does not enforce this. Width
// and height are saturated into 3..MAX_WIDTH / 3..MAX_HEIGHT.
// depends on bbd_pkg, bbd_if and bbd_interp

module bayer_bilinear_demosaic_top #(
   parameter int unsigned MAX_WIDTH  = 4096,
   parameter int unsigned MAX_HEIGHT = 4096,
   parameter int unsigned PIXEL_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   bbd_req_if.sink                           req_chan,
   bbd_rsp_if.source                         rsp_chan,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [bbd_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [bbd_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [bbd_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   localparam int unsigned PW = (PIXEL_BITS < bbd_pkg::SAMPLE_W) ? PIXEL_BITS
                                                                 : bbd_pkg::SAMPLE_W;
   localparam int unsigned CW = $clog2(MAX_WIDTH);
   localparam int unsigned RW = $clog2(MAX_HEIGHT);
   localparam int unsigned FIFO_DEPTH = 3;

   // ---------------------------------------------------------------- registers
   logic [bbd_pkg::DIM_W-1:0]  width_ff,  width_in;
   logic [bbd_pkg::DIM_W-1:0]  height_ff, height_in;
   bbd_pkg::cfa_type           pattern_ff, pattern_in;
   bbd_pkg::csr_index_type     csr_index;
   logic                       csr_write;

   assign csr_pready = 1'b1;
   assign csr_index  = bbd_pkg::csr_index_type'(csr_paddr[3:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // register write decode
   always_comb begin
      width_in   = width_ff;
      height_in  = height_ff;
      pattern_in = pattern_ff;
      if (csr_write) begin
         case (csr_index)
            bbd_pkg::CSR_IMAGE_WIDTH:  width_in   = csr_pwdata[bbd_pkg::DIM_W-1:0];
            bbd_pkg::CSR_IMAGE_HEIGHT: height_in  = csr_pwdata[bbd_pkg::DIM_W-1:0];
            bbd_pkg::CSR_CFA_PATTERN:
               pattern_in = bbd_pkg::cfa_type'(csr_pwdata[bbd_pkg::PATTERN_W-1:0]);
            default: ;
         endcase
      end
   end

   // register read mux
   always_comb begin
      case (csr_index)
         bbd_pkg::CSR_IMAGE_WIDTH:  csr_prdata = bbd_pkg::CSR_DATA_W'(width_ff);
         bbd_pkg::CSR_IMAGE_HEIGHT: csr_prdata = bbd_pkg::CSR_DATA_W'(height_ff);
         bbd_pkg::CSR_CFA_PATTERN:  csr_prdata = bbd_pkg::CSR_DATA_W'(pattern_ff);
         default:                   csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= bbd_pkg::WIDTH_RESET;
         height_ff  <= bbd_pkg::HEIGHT_RESET;
         pattern_ff <= bbd_pkg::cfa_type'(bbd_pkg::PATTERN_RESET);
      end else begin
         width_ff   <= width_in;
         height_ff  <= height_in;
         pattern_ff <= pattern_in;
      end
   end

   // ---------------------------------------------------------------- geometry
   logic [31:0] width_sat;
   logic [31:0] height_sat;
   logic [CW:0] width_dim;
   logic [RW:0] height_dim;

   // saturate the frame size into the supported range
   always_comb begin
      if (32'(width_ff) < 32'd3)                 width_sat = 32'd3;
      else if (32'(width_ff) > 32'(MAX_WIDTH))   width_sat = 32'(MAX_WIDTH);
      else                                       width_sat = 32'(width_ff);
      if (32'(height_ff) < 32'd3)                height_sat = 32'd3;
      else if (32'(height_ff) > 32'(MAX_HEIGHT)) height_sat = 32'(MAX_HEIGHT);
      else                                       height_sat = 32'(height_ff);
   end
   assign width_dim  = width_sat[CW:0];
   assign height_dim = height_sat[RW:0];

   // ---------------------------------------------------------------- stage 0: accept
   logic          req_accept;
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [CW-1:0] cur_col;
   logic [RW-1:0] cur_row;
   logic [CW:0]   col_inc;
   logic [RW:0]   row_inc;
   logic [PW-1:0] cur_pix;
   logic          cur_last;
   logic          cur_produce;

   assign req_accept = req_chan.valid && req_chan.ready;
   assign cur_pix    = req_chan.raw_pixel[PW-1:0];

   // position of the incoming sample, with restart and wrap
   always_comb begin
      if (req_chan.frame_start || ({1'b0, col_ff} >= width_dim)) cur_col = '0;
      else                                                     cur_col = col_ff;
      if (req_chan.frame_start || ({1'b0, row_ff} >= height_dim)) cur_row = '0;
      else                                                      cur_row = row_ff;
   end

   // advance the raster position
   always_comb begin
      col_inc = {1'b0, cur_col} + (CW+1)'(1);
      row_inc = {1'b0, cur_row} + (RW+1)'(1);
      col_in  = col_ff;
      row_in  = row_ff;
      if (req_accept) begin
         if (col_inc >= width_dim) begin
            col_in = '0;
            row_in = (row_inc >= height_dim) ? '0 : row_inc[RW-1:0];
         end else begin
            col_in = col_inc[CW-1:0];
            row_in = cur_row;
         end
      end
   end

   assign cur_last    = ({1'b0, cur_row} == height_dim - (RW+1)'(1))
                     && ({1'b0, cur_col} == width_dim - (CW+1)'(1));
   assign cur_produce = (cur_row >= RW'(2)) && (cur_col >= CW'(2));

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ---------------------------------------------------------------- line memory
   // one entry per column: upper row in the high half, middle row in the low half
   logic [2*PW-1:0] line_mem [MAX_WIDTH];
   logic [2*PW-1:0] mem_rdata_ff;
   logic [2*PW-1:0] mem_wdata;
   logic            mem_we;
   logic            fwd_hit_ff, fwd_hit_in;
   logic [2*PW-1:0] fwd_data_ff;

   // stage 1 registers
   logic            s1_valid_ff, s1_valid_in;
   logic [CW-1:0]   s1_col_ff;
   logic [RW-1:0]   s1_row_ff;
   logic [PW-1:0]   s1_pix_ff;
   logic            s1_last_ff;
   logic            s1_produce_ff;

   always_ff @(posedge clock) begin
      if (mem_we) line_mem[s1_col_ff] <= mem_wdata;
      if (req_accept) mem_rdata_ff <= line_mem[cur_col];
   end

   // a write-back to the column being read in the same cycle is forwarded
   assign fwd_hit_in = s1_valid_ff && (s1_col_ff == cur_col);

   assign s1_valid_in = req_accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_col_ff     <= cur_col;
         s1_row_ff     <= cur_row;
         s1_pix_ff     <= cur_pix;
         s1_last_ff    <= cur_last;
         s1_produce_ff <= cur_produce;
         fwd_hit_ff    <= fwd_hit_in;
         fwd_data_ff   <= mem_wdata;
      end
   end

   // ---------------------------------------------------------------- stage 1: window
   logic [2*PW-1:0] line_word;
   logic [PW-1:0]   top_pix;
   logic [PW-1:0]   mid_pix;
   logic [PW-1:0]   win_ff [6];
   logic [PW-1:0]   win_in [6];
   logic [PW-1:0]   window [9];
   logic [PW-1:0]   red_pix;
   logic [PW-1:0]   green_pix;
   logic [PW-1:0]   blue_pix;
   logic [CW-1:0]   centre_col;
   logic [RW-1:0]   centre_row;

   assign line_word = fwd_hit_ff ? fwd_data_ff : mem_rdata_ff;
   assign top_pix   = line_word[2*PW-1:PW];
   assign mid_pix   = line_word[PW-1:0];

   // rows move up by one in the line memory
   assign mem_we    = s1_valid_ff;
   assign mem_wdata = {mid_pix, s1_pix_ff};

   // 3x3 window in raster order
   assign window[0] = win_ff[0];
   assign window[1] = win_ff[3];
   assign window[2] = top_pix;
   assign window[3] = win_ff[1];
   assign window[4] = win_ff[4];
   assign window[5] = mid_pix;
   assign window[6] = win_ff[2];
   assign window[7] = win_ff[5];
   assign window[8] = s1_pix_ff;

   // shift the two previous columns
   always_comb begin
      win_in = win_ff;
      if (s1_valid_ff) begin
         win_in[0] = win_ff[3];
         win_in[1] = win_ff[4];
         win_in[2] = win_ff[5];
         win_in[3] = top_pix;
         win_in[4] = mid_pix;
         win_in[5] = s1_pix_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int n = 0; n < 6; n++) win_ff[n] <= '0;
      end else begin
         win_ff <= win_in;
      end
   end

   assign centre_col = s1_col_ff - CW'(1);
   assign centre_row = s1_row_ff - RW'(1);

   bbd_interp #(
      .PW (PW)
   ) u_interp (
      .win     (window),
      .pattern (pattern_ff),
      .row_odd (centre_row[0]),
      .col_odd (centre_col[0]),
      .red     (red_pix),
      .green   (green_pix),
      .blue    (blue_pix)
   );

   // ---------------------------------------------------------------- result queue
   bbd_pkg::rsp_item_type result_item;
   bbd_pkg::rsp_item_type fifo_mem [FIFO_DEPTH];
   logic [1:0]            wr_ptr_ff, wr_ptr_in;
   logic [1:0]            rd_ptr_ff, rd_ptr_in;
   logic [1:0]            count_ff, count_in;
   logic                  fifo_push;
   logic                  fifo_pop;
   logic [2:0]            occupancy;

   assign result_item.red       = bbd_pkg::SAMPLE_W'(red_pix);
   assign result_item.green     = bbd_pkg::SAMPLE_W'(green_pix);
   assign result_item.blue      = bbd_pkg::SAMPLE_W'(blue_pix);
   assign result_item.out_col   = bbd_pkg::COORD_W'(centre_col);
   assign result_item.out_row   = bbd_pkg::COORD_W'(centre_row);
   assign result_item.frame_end = s1_last_ff;

   assign fifo_push = s1_valid_ff && s1_produce_ff;
   assign fifo_pop  = rsp_chan.valid && rsp_chan.ready;

   // room for the queued results plus the one in flight
   assign occupancy      = {1'b0, count_ff} + {2'b00, s1_valid_ff};
   assign req_chan.ready = (occupancy < 3'(FIFO_DEPTH));

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (fifo_push) wr_ptr_in = (wr_ptr_ff == 2'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 2'd1;
      if (fifo_pop)  rd_ptr_in = (rd_ptr_ff == 2'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 2'd1;
      if (fifo_push && !fifo_pop)      count_in = count_ff + 2'd1;
      else if (!fifo_push && fifo_pop) count_in = count_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fifo_push) fifo_mem[wr_ptr_ff] <= result_item;
   end

   // result channel
   assign rsp_chan.valid     = (count_ff != 2'd0);
   assign rsp_chan.red       = fifo_mem[rd_ptr_ff].red;
   assign rsp_chan.green     = fifo_mem[rd_ptr_ff].green;
   assign rsp_chan.blue      = fifo_mem[rd_ptr_ff].blue;
   assign rsp_chan.out_col   = fifo_mem[rd_ptr_ff].out_col;
   assign rsp_chan.out_row   = fifo_mem[rd_ptr_ff].out_row;
   assign rsp_chan.frame_end = fifo_mem[rd_ptr_ff].frame_end;

endmodule
